// ===== design/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants, request codes and the table write bundle of the
// Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // Fixed field widths
  localparam int SYM_W  = 8;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;
  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;

  // Table geometry
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int TAB_AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int TLEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int TAB_W  = MAX_CODE_LEN + TLEN_W;

  // Packing datapath
  localparam int LACC_W = BYTE_W - 1;
  localparam int PEND_W = $clog2(BYTE_W);
  localparam int ACC_W  = MAX_CODE_LEN + LACC_W;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_type_t;

  typedef struct packed {
    logic              en;
    logic [TAB_AW-1:0] addr;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } tab_wr_t;

endpackage

// ===== design/hcbp_in_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_in_if
// Request channel: load, encode and flush items with valid/ready.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SYM_W-1:0]  symbol;
  logic [WORD_W-1:0] code_word;
  logic [LEN_W-1:0]  code_len;

  modport source (output valid, req_type, symbol, code_word, code_len, input ready);
  modport sink   (input valid, req_type, symbol, code_word, code_len, output ready);
endinterface

// ===== design/hcbp_out_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_out_if
// Result channel: packed bytes with an end-of-run flag, valid/ready.
// ----------------------------------------------------------------------------
interface hcbp_out_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// ===== design/hcbp_code_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code table memory. Clamps the length and stores the code left aligned
// with zeros below it; one write port, one registered read port.
// ----------------------------------------------------------------------------
module hcbp_code_table (
  input  logic                             clk,
  input  hcbp_pkg::tab_wr_t                wr,
  input  logic                             rd_en,
  input  logic [hcbp_pkg::TAB_AW-1:0]       rd_addr,
  output logic [hcbp_pkg::MAX_CODE_LEN-1:0] rd_code,
  output logic [hcbp_pkg::TLEN_W-1:0]       rd_len
);
  import hcbp_pkg::*;

  localparam int EXT_W = WORD_W + MAX_CODE_LEN;

  logic [TAB_W-1:0]        mem_r [SYMBOL_COUNT];
  logic [TAB_W-1:0]        rd_data_r;
  logic [TLEN_W-1:0]       len_c;
  logic [TLEN_W-1:0]       shamt;
  logic [EXT_W-1:0]        code_ext;
  logic [TAB_W-1:0]        entry;

  // clamp overlong lengths, then left align so unused low bits are zero
  always_comb begin
    if (LEN_W'(wr.len) > LEN_W'(MAX_CODE_LEN)) begin
      len_c = TLEN_W'(MAX_CODE_LEN);
    end else begin
      len_c = TLEN_W'(wr.len);
    end
    shamt    = TLEN_W'(MAX_CODE_LEN) - len_c;
    code_ext = EXT_W'(wr.word) << shamt;
    entry    = {code_ext[MAX_CODE_LEN-1:0], len_c};
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= entry;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_code = rd_data_r[TAB_W-1:TLEN_W];
  assign rd_len  = rd_data_r[TLEN_W-1:0];

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: loads a code table, appends looked-up codes to
// a bit accumulator and emits packed bytes, earliest bit in the MSB.
// ----------------------------------------------------------------------------
// Load: writes the table and stays idle, so ready again on the next cycle. Flush:
//   moves to the emitter for the padded byte if bits are pending.
// Encode: registered table read, a merge state, then one output byte per cycle
//   while the output register is free (0 to 4 bytes at 32-bit codes);
//   the byte emitter sets the pace and the output register holds the last byte.
// Reset (rst_n low, synchronous): idle, output empty, nothing pending; table kept.
module huffman_code_bit_packer (
  input logic        clk,
  input logic        rst_n,
  hcbp_in_if.sink    in_chan,
  hcbp_out_if.source out_chan
);
  import hcbp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [LACC_W-1:0]   lacc_r, lacc_nxt;     // pending bits, left aligned
  logic [PEND_W-1:0]   pend_r, pend_nxt;     // number of pending bits
  logic [ACC_W-1:0]    work_r, work_nxt;     // bits still to emit, left aligned
  logic [CNT_W-1:0]    rem_r, rem_nxt;       // number of bits in work_r
  logic                ok_r, ok_nxt;         // encode symbol inside the table
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  req_type_t           req;
  logic                sym_ok;
  logic                out_free;
  tab_wr_t             tab_wr;
  logic                tab_rd_en;
  logic [MAX_CODE_LEN-1:0] rd_code;
  logic [TLEN_W-1:0]   rd_len;
  logic [ACC_W-1:0]    merged;
  logic [CNT_W-1:0]    total;
  logic [ACC_W-1:0]    work_sh;
  logic [CNT_W-1:0]    rem_dec;
  logic                last_byte;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign req           = req_type_t'(in_chan.req_type);
  assign sym_ok        = ({1'b0, in_chan.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));

  // Load writes the table straight away; encode starts a registered read
  assign tab_wr.en   = accept && (req == REQ_LOAD) && sym_ok;
  assign tab_wr.addr = in_chan.symbol[TAB_AW-1:0];
  assign tab_wr.word = in_chan.code_word;
  assign tab_wr.len  = in_chan.code_len;
  assign tab_rd_en   = accept && (req == REQ_ENCODE);

  hcbp_code_table u_table (
    .clk     (clk),
    .wr      (tab_wr),
    .rd_en   (tab_rd_en),
    .rd_addr (in_chan.symbol[TAB_AW-1:0]),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  // Place the left-aligned code just after the pending bits; the code is
  // stored with zeros below it, so a plain OR joins the two.
  assign merged = {lacc_r, {MAX_CODE_LEN{1'b0}}} | ({rd_code, {LACC_W{1'b0}}} >> pend_r);
  assign total  = CNT_W'(pend_r) + CNT_W'(rd_len);

  // Byte emitter: top byte out, shift the rest up
  assign out_free  = !out_valid_r || out_chan.ready;
  assign work_sh   = work_r << BYTE_W;
  assign rem_dec   = rem_r - CNT_W'(BYTE_W);
  assign last_byte = (rem_r < CNT_W'(2 * BYTE_W));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    lacc_nxt      = lacc_r;
    pend_nxt      = pend_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    // drop the held byte once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_ENCODE: begin
              ok_nxt    = sym_ok;
              state_nxt = ST_MERGE;
            end
            REQ_FLUSH: begin
              // a flush is one byte: pending bits with zero padding below
              if (pend_r != '0) begin
                work_nxt  = {lacc_r, {MAX_CODE_LEN{1'b0}}};
                rem_nxt   = CNT_W'(BYTE_W);
                state_nxt = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_MERGE: begin
        state_nxt = ST_IDLE;
        if (ok_r) begin
          if (total >= CNT_W'(BYTE_W)) begin
            work_nxt  = merged;
            rem_nxt   = total;
            state_nxt = ST_EMIT;
          end else begin
            lacc_nxt = merged[ACC_W-1 -: LACC_W];
            pend_nxt = total[PEND_W-1:0];
          end
        end
      end

      ST_EMIT: begin
        // advance only when the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = work_r[ACC_W-1 -: BYTE_W];
          out_last_nxt  = last_byte;
          work_nxt      = work_sh;
          rem_nxt       = rem_dec;
          if (last_byte) begin
            lacc_nxt  = work_sh[ACC_W-1 -: LACC_W];
            pend_nxt  = rem_dec[PEND_W-1:0];
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lacc_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lacc_r      <= lacc_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    ok_r       <= ok_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.last_of_run = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the emitter only runs with at least one whole byte in hand
  a_emit_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r >= CNT_W'(BYTE_W)))
    else $error("emitter running with less than a byte");

  // bits below the pending count are always zero
  a_lacc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (LACC_W'(lacc_r << pend_r) == '0))
    else $error("stray bits below pending bits");

  // a byte that is not the last of its run keeps the emitter going
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && !last_byte) |=> (state_r == ST_EMIT))
    else $error("emitter stopped before the last byte");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman code bit packer. Loads code words,
// encodes symbols and flushes partial bytes. Every accepted item goes through
// a bit-accurate packing predictor, and each output byte is checked against
// the oldest prediction. A short table of directed items runs first, then
// random items in four handshake-pressure phases.
// ----------------------------------------------------------------------------
module tb;
  import hcbp_pkg::*;

  // Request code that the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int DIR_ROWS        = 25;
  localparam int ITEMS_PER_PHASE = 26;
  localparam int DRAIN_CYCLES    = 24;   // well past the longest encode path

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [SYM_W-1:0]  sym;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  // Directed row: when typed is set, the expected bytes are taken from the row
  // (first byte in the top of bytes) rather than from the predictor.
  typedef struct packed {
    request_t    rq;
    logic        typed;
    logic [2:0]  n_bytes;
    logic [31:0] bytes;
  } dir_row_t;

  logic clk;
  logic rst_n;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // 4 ns clock period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Predictor state: private copy of the code table and the pending bits
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] code_word_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  code_len_mem  [SYMBOL_COUNT];
  bit                is_loaded     [SYMBOL_COUNT];
  int                loaded_syms   [$];
  logic [LACC_W-1:0] held_bits;
  int unsigned       held_count;

  packed_byte_t      expected_bytes [$];
  int                mismatches;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;

  // Idling per phase: none, sender only, receiver only, both lightly
  int unsigned IDLE_PCT  [4] = '{0, 56, 0, 8};
  int unsigned STALL_PCT [4] = '{0, 0, 56, 8};

  // Directed items: after-reset flush, unused code, extreme words and lengths,
  // overlong and zero lengths, single-bit codes and a 33-bit run.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, 3'd0, 32'h0},
    '{'{REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_LOAD,   8'h00, 32'h0000_00A5, 6'd8},  1'b1, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd1, 32'hA500_0000},
    '{'{REQ_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0},  1'b1, 3'd4, 32'hFFFF_FFFF},
    '{'{REQ_LOAD,   8'h01, 32'hFFFF_FFFD, 6'd3},  1'b1, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h01, 32'h0000_0000, 6'd0},  1'b1, 3'd0, 32'h0},
    '{'{REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, 3'd1, 32'hA000_0000},
    '{'{REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b1, 3'd0, 32'h0},
    '{'{REQ_LOAD,   8'h02, 32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h01, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h02, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0},
    '{'{REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0},
    '{'{REQ_LOAD,   8'h03, 32'h1234_5678, 6'd0},  1'b1, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h03, 32'h0000_0000, 6'd0},  1'b1, 3'd0, 32'h0},
    '{'{REQ_LOAD,   8'h04, 32'h0000_0000, 6'd33}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_LOAD,   8'h05, 32'hFFFF_FFFF, 6'd1},  1'b1, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h05, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h04, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h05, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0},
    '{'{REQ_LOAD,   8'h06, 32'h8000_0001, 6'd32}, 1'b1, 3'd0, 32'h0},
    '{'{REQ_ENCODE, 8'h06, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0},
    '{'{REQ_UNUSED, 8'h06, 32'h0000_0000, 6'd0},  1'b1, 3'd0, 32'h0},
    '{'{REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0},  1'b0, 3'd0, 32'h0}
  };

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Packing predictor. Update the private state for one accepted item and,
  // when keep is set, queue the bytes it yields, last flag on the final one.
  // --------------------------------------------------------------------------
  task automatic pack_request(input request_t rq, input bit keep);
    logic [63:0]       acc;
    logic [BYTE_W-1:0] outb [4];
    int unsigned       clen;
    int unsigned       total;
    int                n;
    n = 0;
    case (rq.req)
      REQ_LOAD: begin
        if (rq.sym < SYMBOL_COUNT) begin
          code_word_mem[rq.sym] = rq.word;
          // clamp overlong lengths to the table limit
          code_len_mem[rq.sym]  = (rq.len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : rq.len;
          if (!is_loaded[rq.sym]) begin
            is_loaded[rq.sym] = 1'b1;
            loaded_syms.push_back(rq.sym);
          end
        end
      end
      REQ_ENCODE: begin
        // a zero-length code appends nothing
        if (rq.sym < SYMBOL_COUNT && code_len_mem[rq.sym] != '0) begin
          clen  = code_len_mem[rq.sym];
          acc   = (64'(held_bits) << clen)
                | (64'(code_word_mem[rq.sym]) & ((64'd1 << clen) - 64'd1));
          total = held_count + clen;
          while (total >= 8) begin
            outb[n] = BYTE_W'(acc >> (total - 8));
            n++;
            total -= 8;
          end
          held_bits  = LACC_W'(acc & ((64'd1 << total) - 64'd1));
          held_count = total;
        end
      end
      REQ_FLUSH: begin
        // pad the partial byte with zeros in its low bits
        if (held_count != 0) begin
          outb[0]    = BYTE_W'({1'b0, held_bits} << (8 - held_count));
          n          = 1;
          held_bits  = '0;
          held_count = 0;
        end
      end
      default: ;
    endcase
    if (keep)
      for (int k = 0; k < n; k++)
        expected_bytes.push_back('{data: outb[k], last: (k == n - 1)});
  endtask

  // Random item: mostly encodes of loaded symbols, with loads, flushes and
  // the odd unused code mixed in. Never encode a symbol that was not loaded.
  function automatic request_t random_request();
    request_t    rq;
    int unsigned pick;
    rq.req  = REQ_UNUSED;
    rq.sym  = SYM_W'($urandom);
    rq.word = $urandom;
    rq.len  = LEN_W'($urandom);
    pick    = $urandom_range(99);
    if (pick < 16 || loaded_syms.size() == 0) begin
      rq.req = REQ_LOAD;
      if ($urandom_range(1) == 0)
        rq.sym = SYM_W'($urandom_range(15));   // favour the low entries 0 to 15 so that entries are revisited
      case ($urandom_range(9))
        0:       rq.len = '0;
        1:       rq.len = LEN_W'($urandom_range(63, 33));
        2:       rq.len = LEN_W'(MAX_CODE_LEN);
        default: rq.len = LEN_W'($urandom_range(32, 1));
      endcase
      case ($urandom_range(7))
        0:       rq.word = '0;
        1:       rq.word = '1;
        default: ;
      endcase
    end else if (pick < 82) begin
      rq.req = REQ_ENCODE;
      rq.sym = SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
    end else if (pick < 94) begin
      rq.req = REQ_FLUSH;
    end
    return rq;
  endfunction

  // Drive one item at the falling edge, idling first at random; hold it until
  // it is accepted at a rising edge.
  task automatic send_request(input request_t rq);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= rq.req;
    in_ch.symbol    <= rq.sym;
    in_ch.code_word <= rq.word;
    in_ch.code_len  <= rq.len;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stall the result channel at random, changing ready at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each accepted byte against the oldest prediction
  always @(posedge clk) begin : check_bytes
    packed_byte_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 32'h0, 32'(out_ch.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.out_byte !== want.data)
          report_mismatch("out_byte", 32'(want.data), 32'(out_ch.out_byte));
        if (out_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(want.last), 32'(out_ch.last_of_run));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random items in four phases
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    request_t rq;
    int       k;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_FLUSH;
    in_ch.symbol    = '0;
    in_ch.code_word = '0;
    in_ch.code_len  = '0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    mismatches      = 0;
    held_bits       = '0;
    held_count      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling on either side
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.rq);
      pack_request(row.rq, !row.typed);
      if (row.typed)
        for (k = 0; k < row.n_bytes; k++)
          expected_bytes.push_back('{data: row.bytes[31 - 8 * k -: 8],
                                     last: (k == row.n_bytes - 1)});
    end

    // Random part: the pressure changes only between phases
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = IDLE_PCT[phase];
      recv_stall_pct = STALL_PCT[phase];
      repeat (ITEMS_PER_PHASE) begin
        rq = random_request();
        send_request(rq);
        pack_request(rq, 1'b1);
      end
    end

    // Drop valid, drain the expected bytes, then watch for strays
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: stops the run long after the slowest legal run would end
  initial begin
    #400_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
design/hcbp_pkg.sv
design/hcbp_in_if.sv
design/hcbp_out_if.sv
design/hcbp_code_table.sv
design/huffman_code_bit_packer.sv
verif/tb.sv
